// ===== hdl/bto_pkg.sv =====
package bto_pkg;

  typedef struct packed {
    logic [31:0] spot_price;
    logic [31:0] strike_price;
    logic        is_call;
  } in_item_t;

  typedef struct packed {
    logic [31:0] option_price;
    logic        saturated;
  } result_t;

  typedef struct packed {
    logic [19:0] maturity_years;
    logic [16:0] interest_rate;
    logic [17:0] volatility;
    logic [10:0] tree_steps;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic take;
  } eng_stat_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MATURITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS    = 3'd3;

  localparam logic [19:0] MATURITY_RST = 20'd2693;
  localparam logic [16:0] RATE_RST     = 17'd3277;
  localparam logic [17:0] VOL_RST      = 18'd13107;
  localparam logic [10:0] STEPS_RST    = 11'd1000;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;
  localparam logic [4:0]  TAYLOR_TERMS = 5'd16;

  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 33;

  localparam int ITEM_QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

endpackage

// ===== hdl/bto_item_queue.sv =====
module bto_item_queue import bto_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t item,
  output logic     full,
  output logic     valid,
  input  logic     take,
  output in_item_t head
);

  in_item_t          entries [ITEM_QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_take;

  assign full    = (count == QCNT_W'(ITEM_QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_take = take && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(ITEM_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(ITEM_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_take) begin
        count <= count + 1'b1;
      end else if (do_take && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/bto_div.sv =====
module bto_div import bto_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  logic               run;
  logic [6:0]         cnt;
  logic [DIV_D_W-1:0] dsr;
  logic [DIV_D_W-1:0] remainder;
  logic [DIV_D_W:0]   shifted;
  logic               ge;

  // restoring, one quotient bit a cycle
  assign shifted = {remainder, quotient[DIV_N_W-1]};
  assign ge      = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient  <= dividend;
        remainder <= '0;
        dsr       <= divisor;
        cnt       <= 7'(DIV_N_W);
        run       <= 1'b1;
      end else if (run) begin
        remainder <= ge ? DIV_D_W'(shifted - {1'b0, dsr}) : DIV_D_W'(shifted);
        quotient  <= {quotient[DIV_N_W-2:0], ge};
        cnt       <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/bto_engine.sv =====
module bto_engine import bto_pkg::*; #(
  parameter int MAX_STEPS = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      item_valid,
  input  in_item_t  item,
  output eng_stat_t stat,
  output logic      res_valid,
  output result_t   res,
  input  logic      res_pop
);

  localparam int AW = $clog2(MAX_STEPS + 1);

  typedef enum logic [4:0] {
    IDLE, DT_W, SQRT, XMUL, RMUL, EXP_START, EXP_KW, EXP_MUL, EXP_TW, EXP_FIN,
    D_START, D_W, P_SEL, P_W, LEAF_INIT, LEAF_RUN, BACK, DONE
  } state_t;

  localparam logic [1:0] EXP_U = 2'd0;
  localparam logic [1:0] EXP_A = 2'd1;
  localparam logic [1:0] EXP_D = 2'd2;

  state_t st;

  logic               div_start;
  logic [DIV_N_W-1:0] div_a;
  logic [DIV_D_W-1:0] div_b;
  logic               div_done;
  logic [DIV_N_W-1:0] div_q;

  logic [AW-1:0] n_eff;
  logic [31:0]   spot;
  logic [31:0]   strike;
  logic          call;
  logic          sat;

  logic [63:0] dt60;
  logic [63:0] sq_rv;
  logic [63:0] sq_root;
  logic [63:0] sq_bit;
  logic [63:0] sq_try;
  logic [33:0] x;
  logic [34:0] rdt_mag;
  logic        rdt_neg;
  logic [16:0] rmag;
  logic [49:0] x_prod;
  logic [50:0] r_prod;

  logic [1:0]        exp_sel;
  logic              ey_neg;
  logic [34:0]       ey_mag;
  logic [34:0]       k_rem;
  logic [8:0]        k_cnt;
  logic signed [8:0] ek;
  logic [29:0]       ef;
  logic [30:0]       eterm;
  logic [32:0]       esum;
  logic [4:0]        en;
  logic [60:0]       t_prod;
  logic [31:0]       exp_val;
  logic              exp_sat;
  logic [33:0]       exp_dbl;
  logic [8:0]        exp_sh;

  logic [31:0] u;
  logic [31:0] d;
  logic [31:0] a;
  logic [31:0] disc;
  logic [30:0] p;

  logic [AW-1:0] lj;
  logic [AW-1:0] lcnt;
  logic          ldown;
  logic [31:0]   lv;
  logic [AW:0]   lj2;
  logic [63:0]   lprod;
  logic          leaf_stop;
  logic [31:0]   payoff;

  logic [AW-1:0] lvl;
  logic [AW-1:0] ra;
  logic          bk_issued;
  logic          bk_issue;
  logic          pipe_empty;

  // backward pipeline
  logic               rv0;
  logic [AW-1:0]      ri0;
  logic [31:0]        prev;
  logic               s1_v;
  logic [AW-1:0]      s1_j;
  logic [31:0]        s1_b;
  logic signed [32:0] s1_diff;
  logic               s2_v;
  logic [AW-1:0]      s2_j;
  logic [31:0]        s2_b;
  logic signed [65:0] s2_prod;
  logic signed [65:0] s3_sum;
  logic               s3_v;
  logic [AW-1:0]      s3_j;
  logic [31:0]        s3_mix;
  logic               s4_v;
  logic [AW-1:0]      s4_j;
  logic [63:0]        s4_prod;
  logic               bk_clip;
  logic [31:0]        bk_val;
  logic [31:0]        root;

  logic [31:0]   mem [MAX_STEPS+1];
  logic [31:0]   mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;

  assign stat.busy = (st != IDLE);
  assign stat.take = (st == IDLE) && item_valid;

  bto_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q)
  );

  assign sq_try = sq_root + sq_bit;
  assign x_prod = cfg.volatility * sq_root[31:0];
  assign rmag   = cfg.interest_rate[16] ? 17'(-cfg.interest_rate) : cfg.interest_rate;
  assign r_prod = rmag * dt60[63:30];
  assign t_prod = eterm * ef;

  always_comb begin
    ey_neg = 1'b0;
    ey_mag = {1'b0, x};
    case (exp_sel)
      EXP_A: begin
        ey_neg = rdt_neg;
        ey_mag = rdt_mag;
      end
      EXP_D: begin
        ey_neg = !rdt_neg;
        ey_mag = rdt_mag;
      end
      default: ;
    endcase
  end

  // scale the series by 2^k and clip
  always_comb begin
    exp_sat = 1'b0;
    exp_val = '0;
    exp_sh  = 9'(-ek);
    exp_dbl = {esum, 1'b0};
    if (ek >= 2) begin
      exp_sat = 1'b1;
      exp_val = MAX32;
    end else if (ek == 1) begin
      if (exp_dbl > {2'b0, MAX32}) begin
        exp_sat = 1'b1;
        exp_val = MAX32;
      end else begin
        exp_val = exp_dbl[31:0];
      end
    end else if (ek == 0) begin
      if (esum > {1'b0, MAX32}) begin
        exp_sat = 1'b1;
        exp_val = MAX32;
      end else begin
        exp_val = esum[31:0];
      end
    end else if (exp_sh >= 9'd32) begin
      exp_val = '0;
    end else begin
      exp_val = 32'(esum >> exp_sh[4:0]);
    end
  end

  assign lj2       = {lj, 1'b0};
  assign lprod     = lv * (ldown ? d : u);
  assign leaf_stop = (lcnt == '0) || (ldown && (lv == '0));

  always_comb begin
    if (call) begin
      payoff = (lv > strike) ? lv - strike : '0;
    end else begin
      payoff = (strike > lv) ? strike - lv : '0;
    end
  end

  assign bk_issue   = (st == BACK) && !bk_issued;
  assign pipe_empty = !(rv0 || s1_v || s2_v || s3_v || s4_v);
  assign s3_sum     = $signed({4'b0, s2_b, 30'b0}) + s2_prod;
  assign bk_clip    = (s4_prod[63:62] != 2'b00);
  assign bk_val     = bk_clip ? MAX32 : s4_prod[61:30];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = s4_j;
    mem_wd = bk_val;
    if (s4_v) begin
      mem_we = 1'b1;
    end else if ((st == LEAF_RUN) && leaf_stop) begin
      mem_we = 1'b1;
      mem_wa = lj;
      mem_wd = payoff;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[ra];
  end

  // one node a cycle within a level, draining between levels: read, difference, p*(a-b), mix, discount, write back
  always_ff @(posedge clk) begin
    if (rst) begin
      rv0  <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      rv0 <= bk_issue;
      ri0 <= ra;
      s1_v <= 1'b0;
      if (rv0) begin
        prev <= mem_q;
        if (ri0 != '0) begin
          s1_v    <= 1'b1;
          s1_j    <= ri0 - 1'b1;
          s1_b    <= mem_q;
          s1_diff <= $signed({1'b0, prev}) - $signed({1'b0, mem_q});
        end
      end
      s2_v    <= s1_v;
      s2_j    <= s1_j;
      s2_b    <= s1_b;
      s2_prod <= 66'($signed({1'b0, p}) * s1_diff);
      s3_v    <= s2_v;
      s3_j    <= s2_j;
      s3_mix  <= s3_sum[61:30];
      s4_v    <= s3_v;
      s4_j    <= s3_j;
      s4_prod <= s3_mix * disc;
      if (s4_v && (s4_j == '0)) begin
        root <= bk_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= IDLE;
      div_start <= 1'b0;
      res_valid <= 1'b0;
      sat       <= 1'b0;
      bk_issued <= 1'b0;
      u         <= '0;
      d         <= '0;
      p         <= '0;
      disc      <= '0;
    end else begin
      div_start <= 1'b0;
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (s4_v && bk_clip) begin
        sat <= 1'b1;
      end
      unique case (st)
        IDLE: begin
          if (item_valid) begin
            spot   <= item.spot_price;
            strike <= item.strike_price;
            call   <= item.is_call;
            sat    <= 1'b0;
            if (cfg.tree_steps == '0) begin
              n_eff <= AW'(1);
            end else if (32'(cfg.tree_steps) > MAX_STEPS) begin
              n_eff <= AW'(MAX_STEPS);
            end else begin
              n_eff <= AW'(cfg.tree_steps);
            end
            div_a     <= {cfg.maturity_years, 44'b0};
            div_b     <= DIV_D_W'(cfg.tree_steps == '0 ? 11'd1 :
                         (32'(cfg.tree_steps) > MAX_STEPS ? 11'(MAX_STEPS) :
                          cfg.tree_steps));
            div_start <= 1'b1;
            st        <= DT_W;
          end
        end
        DT_W: begin
          if (div_done) begin
            dt60    <= div_q;
            sq_rv   <= div_q;
            sq_root <= '0;
            sq_bit  <= 64'h4000_0000_0000_0000;
            st      <= SQRT;
          end
        end
        SQRT: begin
          if (sq_rv >= sq_try) begin
            sq_rv   <= sq_rv - sq_try;
            sq_root <= (sq_root >> 1) + sq_bit;
          end else begin
            sq_root <= sq_root >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            st <= XMUL;
          end
        end
        XMUL: begin
          x  <= x_prod[49:16];
          st <= RMUL;
        end
        RMUL: begin
          rdt_mag <= r_prod[50:16];
          rdt_neg <= cfg.interest_rate[16];
          exp_sel <= EXP_U;
          st      <= EXP_START;
        end
        EXP_START: begin
          k_rem <= ey_mag;
          k_cnt <= '0;
          st    <= EXP_KW;
        end
        EXP_KW: begin
          // k = |y| / ln2 by repeated subtraction
          if (k_rem >= 35'(LN2_Q30)) begin
            k_rem <= k_rem - 35'(LN2_Q30);
            k_cnt <= k_cnt + 1'b1;
          end else begin
            if (!ey_neg) begin
              ek <= k_cnt;
              ef <= k_rem[29:0];
            end else if (k_rem == '0) begin
              ek <= -k_cnt;
              ef <= '0;
            end else begin
              ek <= -k_cnt - 9'sd1;
              ef <= LN2_Q30 - k_rem[29:0];
            end
            eterm <= ONE_Q30;
            esum  <= {2'b0, ONE_Q30};
            en    <= 5'd1;
            st    <= EXP_MUL;
          end
        end
        EXP_MUL: begin
          div_a     <= DIV_N_W'(t_prod[60:30]);
          div_b     <= DIV_D_W'(en);
          div_start <= 1'b1;
          st        <= EXP_TW;
        end
        EXP_TW: begin
          if (div_done) begin
            eterm <= div_q[30:0];
            esum  <= esum + {2'b0, div_q[30:0]};
            if (en == TAYLOR_TERMS) begin
              st <= EXP_FIN;
            end else begin
              en <= en + 1'b1;
              st <= EXP_MUL;
            end
          end
        end
        EXP_FIN: begin
          if (exp_sat) begin
            sat <= 1'b1;
          end
          case (exp_sel)
            EXP_U: begin
              u       <= exp_val;
              exp_sel <= EXP_A;
              st      <= EXP_START;
            end
            EXP_A: begin
              a       <= exp_val;
              exp_sel <= EXP_D;
              st      <= EXP_START;
            end
            default: begin
              disc <= exp_val;
              st   <= D_START;
            end
          endcase
        end
        D_START: begin
          div_a     <= 64'h1000_0000_0000_0000;
          div_b     <= DIV_D_W'(u);
          div_start <= 1'b1;
          st        <= D_W;
        end
        D_W: begin
          if (div_done) begin
            d  <= div_q[31:0];
            st <= P_SEL;
          end
        end
        P_SEL: begin
          lj <= '0;
          if (u == d) begin
            p  <= HALF_Q30;
            st <= LEAF_INIT;
          end else if (a <= d) begin
            p  <= '0;
            st <= LEAF_INIT;
          end else if (a >= u) begin
            p  <= ONE_Q30;
            st <= LEAF_INIT;
          end else begin
            div_a     <= {2'b0, a - d, 30'b0};
            div_b     <= DIV_D_W'(u - d);
            div_start <= 1'b1;
            st        <= P_W;
          end
        end
        P_W: begin
          if (div_done) begin
            p  <= div_q[30:0];
            st <= LEAF_INIT;
          end
        end
        LEAF_INIT: begin
          lv <= spot;
          if ({1'b0, n_eff} >= lj2) begin
            lcnt  <= AW'({1'b0, n_eff} - lj2);
            ldown <= 1'b0;
          end else begin
            lcnt  <= AW'(lj2 - {1'b0, n_eff});
            ldown <= 1'b1;
          end
          st <= LEAF_RUN;
        end
        LEAF_RUN: begin
          if (leaf_stop) begin
            if (lj == n_eff) begin
              lvl       <= n_eff;
              ra        <= '0;
              bk_issued <= 1'b0;
              st        <= BACK;
            end else begin
              lj <= lj + 1'b1;
              st <= LEAF_INIT;
            end
          end else if (!ldown && (lprod[63:62] != 2'b00)) begin
            lv   <= MAX32;
            sat  <= 1'b1;
            lcnt <= '0;
          end else begin
            lv   <= lprod[61:30];
            lcnt <= lcnt - 1'b1;
          end
        end
        BACK: begin
          if (bk_issue) begin
            if (ra == lvl) begin
              bk_issued <= 1'b1;
            end else begin
              ra <= ra + 1'b1;
            end
          end else if (pipe_empty) begin
            if (lvl == AW'(1)) begin
              st <= DONE;
            end else begin
              lvl       <= lvl - 1'b1;
              ra        <= '0;
              bk_issued <= 1'b0;
            end
          end
        end
        DONE: begin
          if (!res_valid) begin
            res_valid        <= 1'b1;
            res.option_price <= root;
            res.saturated    <= sat;
            st               <= IDLE;
          end
        end
        default: st <= IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/binomial_tree_option_pricer.sv =====
// Cox-Ross-Rubinstein pricer for one European option per item. Items enter a
// two-deep queue and are priced one at a time; the result waits in an output
// register until popped, while the queue keeps taking items. Setup uses one
// shared serial divider (step length, 16 series terms for each of three
// exponentials, down factor, probability), a square root and an ln2 range
// reduction that subtracts once a cycle; leaf prices take one multiply per
// cycle, up to |N-2j| of them for leaf j of N effective steps; the backward
// fold runs one node a cycle through a five-stage update pipeline reading
// the node memory, with a short drain per level.
// The user must write configuration only while idle; the block does not
// enforce it, and cfg_ready is always high.
module binomial_tree_option_pricer import bto_pkg::*; #(
  parameter int MAX_STEPS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              item,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      q_valid;
  in_item_t  q_head;
  eng_stat_t eng_stat;
  logic      res_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.maturity_years <= MATURITY_RST;
      cfg.interest_rate  <= RATE_RST;
      cfg.volatility     <= VOL_RST;
      cfg.tree_steps     <= STEPS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MATURITY: cfg.maturity_years <= cfg_data;
        CFG_RATE:     cfg.interest_rate  <= cfg_data[16:0];
        CFG_VOL:      cfg.volatility     <= cfg_data[17:0];
        CFG_STEPS:    cfg.tree_steps     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  bto_item_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .full  (full),
    .valid (q_valid),
    .take  (eng_stat.take),
    .head  (q_head)
  );

  bto_engine #(
    .MAX_STEPS (MAX_STEPS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item       (q_head),
    .stat       (eng_stat),
    .res_valid  (res_valid),
    .res        (result),
    .res_pop    (pop)
  );

  a_reset_clean: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue or result not clear after reset");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(eng_stat.busy))
    else $error("result appeared with no item in work");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    eng_stat.take |=> eng_stat.busy)
    else $error("engine took an item but did not start");

endmodule
